@@ design/cpu8alu_pkg.sv @@
// package: operation codes and flag type for the 8-bit alu
package cpu8alu_pkg;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_ADC  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_SBC  = 5'd3;
  localparam logic [4:0] OP_AND  = 5'd4;
  localparam logic [4:0] OP_XOR  = 5'd5;
  localparam logic [4:0] OP_OR   = 5'd6;
  localparam logic [4:0] OP_CP   = 5'd7;
  localparam logic [4:0] OP_INC  = 5'd8;
  localparam logic [4:0] OP_DEC  = 5'd9;
  localparam logic [4:0] OP_RLCA = 5'd10;
  localparam logic [4:0] OP_RRCA = 5'd11;
  localparam logic [4:0] OP_RLA  = 5'd12;
  localparam logic [4:0] OP_RRA  = 5'd13;
  localparam logic [4:0] OP_DAA  = 5'd14;
  localparam logic [4:0] OP_CPL  = 5'd15;
  localparam logic [4:0] OP_SCF  = 5'd16;
  localparam logic [4:0] OP_CCF  = 5'd17;
  localparam logic [4:0] OP_RLC  = 5'd18;
  localparam logic [4:0] OP_RRC  = 5'd19;
  localparam logic [4:0] OP_RL   = 5'd20;
  localparam logic [4:0] OP_RR   = 5'd21;
  localparam logic [4:0] OP_SLA  = 5'd22;
  localparam logic [4:0] OP_SRA  = 5'd23;
  localparam logic [4:0] OP_SWAP = 5'd24;
  localparam logic [4:0] OP_SRL  = 5'd25;
  localparam logic [4:0] OP_BIT  = 5'd26;
  localparam logic [4:0] OP_RES  = 5'd27;
  localparam logic [4:0] OP_SET  = 5'd28;

  localparam logic [7:0] BCD_MAX_BYTE  = 8'h99;
  localparam logic [3:0] BCD_MAX_DIGIT = 4'h9;
  localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ    = 8'h60;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

@@ design/cpu8alu_calc.sv @@
// combinational alu: result byte, write-enable and new flags for one operation
module cpu8alu_calc
  import cpu8alu_pkg::*;
(
  input  logic [4:0] cmd,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [2:0] bit_index,
  input  flags_t     flags_in,
  output logic [7:0] result,
  output logic       write_back,
  output flags_t     flags_out
);

  always_comb begin
    logic       k;
    logic [8:0] sum9;
    logic [4:0] hsum5;
    logic [8:0] sub_rhs9;
    logic [4:0] hsub_rhs5;
    logic [7:0] adj;
    logic [7:0] mask;
    logic       zr;

    k         = 1'b0;
    sum9      = 9'd0;
    hsum5     = 5'd0;
    sub_rhs9  = 9'd0;
    hsub_rhs5 = 5'd0;
    adj       = 8'd0;
    mask      = 8'd1 << bit_index;
    zr        = 1'b0;

    result     = operand_a;
    write_back = 1'b1;
    flags_out  = flags_in;

    case (cmd)
      OP_ADD, OP_ADC: begin
        k           = (cmd == OP_ADC) ? flags_in.c : 1'b0;
        sum9        = {1'b0, operand_a} + {1'b0, operand_b} + {8'd0, k};
        hsum5       = {1'b0, operand_a[3:0]} + {1'b0, operand_b[3:0]} + {4'd0, k};
        result      = sum9[7:0];
        flags_out.n = 1'b0;
        flags_out.h = hsum5[4];
        flags_out.c = sum9[8];
        zr          = 1'b1;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        k           = (cmd == OP_SBC) ? flags_in.c : 1'b0;
        sub_rhs9    = {1'b0, operand_b} + {8'd0, k};
        hsub_rhs5   = {1'b0, operand_b[3:0]} + {4'd0, k};
        result      = operand_a - operand_b - {7'd0, k};
        flags_out.n = 1'b1;
        flags_out.h = {1'b0, operand_a[3:0]} < hsub_rhs5;
        flags_out.c = {1'b0, operand_a} < sub_rhs9;
        zr          = 1'b1;
        if (cmd == OP_CP) begin
          write_back = 1'b0;
        end
      end
      OP_AND: begin
        result    = operand_a & operand_b;
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b1, c: 1'b0};
        zr        = 1'b1;
      end
      OP_XOR: begin
        result    = operand_a ^ operand_b;
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
        zr        = 1'b1;
      end
      OP_OR: begin
        result    = operand_a | operand_b;
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
        zr        = 1'b1;
      end
      OP_INC: begin
        result      = operand_a + 8'd1;
        flags_out.n = 1'b0;
        flags_out.h = (operand_a[3:0] == 4'hf);
        zr          = 1'b1;
      end
      OP_DEC: begin
        result      = operand_a - 8'd1;
        flags_out.n = 1'b1;
        flags_out.h = (operand_a[3:0] == 4'h0);
        zr          = 1'b1;
      end
      OP_RLCA, OP_RLC: begin
        flags_out.c = operand_a[7];
        result      = {operand_a[6:0], operand_a[7]};
      end
      OP_RRCA, OP_RRC: begin
        flags_out.c = operand_a[0];
        result      = {operand_a[0], operand_a[7:1]};
      end
      OP_RLA, OP_RL: begin
        flags_out.c = operand_a[7];
        result      = {operand_a[6:0], flags_in.c};
      end
      OP_RRA, OP_RR: begin
        flags_out.c = operand_a[0];
        result      = {flags_in.c, operand_a[7:1]};
      end
      OP_SLA: begin
        flags_out.c = operand_a[7];
        result      = {operand_a[6:0], 1'b0};
      end
      OP_SRA: begin
        flags_out.c = operand_a[0];
        result      = {operand_a[7], operand_a[7:1]};
      end
      OP_SWAP: begin
        flags_out.c = 1'b0;
        result      = {operand_a[3:0], operand_a[7:4]};
      end
      OP_SRL: begin
        flags_out.c = operand_a[0];
        result      = {1'b0, operand_a[7:1]};
      end
      OP_DAA: begin
        if (flags_in.h || (!flags_in.n && (operand_a[3:0] > BCD_MAX_DIGIT))) begin
          adj = adj | DAA_LO_ADJ;
        end
        if (flags_in.c || (!flags_in.n && (operand_a > BCD_MAX_BYTE))) begin
          adj         = adj | DAA_HI_ADJ;
          flags_out.c = 1'b1;
        end
        result      = flags_in.n ? (operand_a - adj) : (operand_a + adj);
        flags_out.h = 1'b0;
        zr          = 1'b1;
      end
      OP_CPL: begin
        result      = ~operand_a;
        flags_out.n = 1'b1;
        flags_out.h = 1'b1;
      end
      OP_SCF: begin
        write_back  = 1'b0;
        flags_out.n = 1'b0;
        flags_out.h = 1'b0;
        flags_out.c = 1'b1;
      end
      OP_CCF: begin
        write_back  = 1'b0;
        flags_out.n = 1'b0;
        flags_out.h = 1'b0;
        flags_out.c = ~flags_in.c;
      end
      OP_BIT: begin
        write_back  = 1'b0;
        flags_out.z = ~|(operand_a & mask);
        flags_out.n = 1'b0;
        flags_out.h = 1'b1;
      end
      OP_RES: begin
        result = operand_a & ~mask;
      end
      OP_SET: begin
        result = operand_a | mask;
      end
      default: begin
        write_back = 1'b0;
      end
    endcase

    // accumulator rotates clear z, n and h
    if (cmd inside {[OP_RLCA:OP_RRA]}) begin
      flags_out.z = 1'b0;
      flags_out.n = 1'b0;
      flags_out.h = 1'b0;
    end
    // cb rotates and shifts
    if (cmd inside {[OP_RLC:OP_SRL]}) begin
      zr          = 1'b1;
      flags_out.n = 1'b0;
      flags_out.h = 1'b0;
    end
    if (zr) begin
      flags_out.z = (result == 8'd0);
    end
  end

endmodule

@@ design/cpu8_alu_with_flags_core.sv @@
// top level: registered 8-bit alu with flags, input stage and result stage
//
// Eight-bit ALU with Z/N/H/C flags. Each beat carries one operation and gives
// one result beat, held first in the input register and then in the result
// register; a new beat can be accepted every cycle while in_stall is low. The
// operation is evaluated in one pass of combinational logic between the two
// registers, so the throughput is one beat per cycle while out_stall is low.
// in_stall rises only when both stages hold a beat and the result side stalls.
module cpu8_alu_with_flags_core
  import cpu8alu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_cmd,
  input  logic [7:0] in_operand_a,
  input  logic [7:0] in_operand_b,
  input  logic [2:0] in_bit_index,
  input  logic       in_zero_in,
  input  logic       in_subtract_in,
  input  logic       in_half_carry_in,
  input  logic       in_carry_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_result,
  output logic       out_write_back,
  output logic       out_zero_out,
  output logic       out_subtract_out,
  output logic       out_half_carry_out,
  output logic       out_carry_out
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [4:0] s1_cmd_r;
  logic [7:0] s1_a_r;
  logic [7:0] s1_b_r;
  logic [2:0] s1_bit_r;
  flags_t     s1_flags_r;

  logic       s2_valid_r;
  logic       s2_valid_nxt;
  logic [7:0] s2_result_r;
  logic       s2_wb_r;
  flags_t     s2_flags_r;

  logic       s2_load;
  logic       s1_load;
  logic [7:0] calc_result;
  logic       calc_wb;
  flags_t     calc_flags;

  assign s2_load  = s1_valid_r && (!s2_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r   <= in_cmd;
      s1_a_r     <= in_operand_a;
      s1_b_r     <= in_operand_b;
      s1_bit_r   <= in_bit_index;
      s1_flags_r <= '{z: in_zero_in, n: in_subtract_in, h: in_half_carry_in,
                      c: in_carry_in};
    end
  end

  cpu8alu_calc u_calc (
    .cmd        (s1_cmd_r),
    .operand_a  (s1_a_r),
    .operand_b  (s1_b_r),
    .bit_index  (s1_bit_r),
    .flags_in   (s1_flags_r),
    .result     (calc_result),
    .write_back (calc_wb),
    .flags_out  (calc_flags)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_result_r <= calc_result;
      s2_wb_r     <= calc_wb;
      s2_flags_r  <= calc_flags;
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_result         = s2_result_r;
  assign out_write_back     = s2_wb_r;
  assign out_zero_out       = s2_flags_r.z;
  assign out_subtract_out   = s2_flags_r.n;
  assign out_half_carry_out = s2_flags_r.h;
  assign out_carry_out      = s2_flags_r.c;

endmodule
